// ----- hw/rtl/bale_pkg.sv -----
package bale_pkg;

  // Command codes on the command input
  typedef enum logic [3:0] {
    CMD_INS_FRONT  = 4'd0,
    CMD_INS_REAR   = 4'd1,
    CMD_INS_SORTED = 4'd2,
    CMD_INS_AT     = 4'd3,
    CMD_SEARCH     = 4'd4,
    CMD_DEL_FRONT  = 4'd5,
    CMD_DEL_REAR   = 4'd6,
    CMD_DEL_AT     = 4'd7,
    CMD_DEL_ITEM   = 4'd8,
    CMD_DEL_ALL    = 4'd9
  } cmd_t;

  // Result status codes
  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_FULL     = 3'd1,
    STS_EMPTY    = 3'd2,
    STS_BADLOC   = 3'd3,
    STS_NOTFOUND = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RUN,
    S_INS_LAST,
    S_SCAN,
    S_FINISH
  } state_t;

  localparam int unsigned WORD_W = 32;

endpackage

// ----- hw/rtl/bale_ram.sv -----
module bale_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/bounded_array_list_engine.sv -----
// Ordered list of up to DEPTH signed 32-bit words, kept packed at positions
// 0..count-1 in a single-port-write, registered-read RAM. One command is taken
// at a time; in_stall stays high until its result is handed to the output
// register. Inserts walk backward from the tail moving one word up per cycle;
// search and deletes walk forward over every held word, and deletes compact
// survivors toward the front as they go. Error cases and unused command codes
// go straight to the finish state without a RAM walk.
module bounded_array_list_engine import bale_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [3:0]                            command,
  input  logic signed [WORD_W-1:0]              item_value,
  input  logic [$clog2(DEPTH+1)-1:0]            location,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [2:0]                            status,
  output logic signed [WORD_W-1:0]              result_value,
  output logic [$clog2(DEPTH+1)-1:0]            removed_count,
  output logic [$clog2(DEPTH+1)-1:0]            element_count
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // Sequencer and datapath registers
  state_t                   state, state_next;
  cmd_t                     cmd, cmd_next;
  logic signed [WORD_W-1:0] item, item_next;
  logic [CW-1:0]            count, count_next;
  logic [CW-1:0]            pos, pos_next;
  logic [AW-1:0]            idx, idx_next;
  logic [AW-1:0]            wptr, wptr_next;
  logic [CW-1:0]            hits, hits_next;
  logic signed [WORD_W-1:0] val, val_next;
  status_t                  sts, sts_next;

  // RAM port signals
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [WORD_W-1:0]        ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [WORD_W-1:0]        ram_rdata;

  bale_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic accept;
  logic out_free;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Decode of an incoming command
  cmd_t          in_cmd;
  logic          in_ins;
  logic          in_done;
  status_t       in_sts;
  logic [CW-1:0] in_pos;
  logic          in_direct;

  always_comb begin
    in_cmd    = cmd_t'(command);
    in_ins    = in_cmd inside {CMD_INS_FRONT, CMD_INS_REAR, CMD_INS_SORTED, CMD_INS_AT};
    in_done   = 1'b0;
    in_sts    = STS_OK;
    in_pos    = count;
    in_direct = 1'b0;
    case (in_cmd)
      CMD_INS_FRONT:           in_pos = '0;
      CMD_INS_AT, CMD_DEL_AT:  in_pos = location;
      default:                 in_pos = count;
    endcase
    if (in_ins) begin
      if (count == DEPTH_C) begin
        in_done = 1'b1;
        in_sts  = STS_FULL;
      end else if ((in_cmd == CMD_INS_AT) && (location > count)) begin
        in_done = 1'b1;
        in_sts  = STS_BADLOC;
      end else begin
        in_direct = (count == '0) ||
                    ((in_cmd != CMD_INS_SORTED) && (in_pos == count));
      end
    end else if (in_cmd inside {[CMD_SEARCH:CMD_DEL_ALL]}) begin
      if (count == '0) begin
        in_done = 1'b1;
        in_sts  = STS_EMPTY;
      end else if ((in_cmd == CMD_DEL_AT) && (location >= count)) begin
        in_done = 1'b1;
        in_sts  = STS_BADLOC;
      end
    end else begin
      in_done = 1'b1;
    end
  end

  // Shared compare unit on the word read back from the RAM
  logic          word_eq;
  logic          word_gt;
  logic          ins_shift;
  logic          scan_take;
  logic          scan_last;
  logic [CW-1:0] idx_c;

  always_comb begin
    word_eq   = (ram_rdata == item);
    word_gt   = ($signed(ram_rdata) > item);
    idx_c     = CW'(idx);
    ins_shift = (cmd == CMD_INS_SORTED) ? word_gt : (idx_c >= pos);
    scan_last = (idx_c == (count - ONE_C));
    case (cmd)
      CMD_DEL_FRONT:             scan_take = (idx == '0);
      CMD_DEL_REAR:              scan_take = scan_last;
      CMD_DEL_AT:                scan_take = (idx_c == pos);
      CMD_DEL_ALL:               scan_take = word_eq;
      CMD_SEARCH, CMD_DEL_ITEM:  scan_take = word_eq && (hits == '0);
      default:                   scan_take = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_done) begin
            state_next = S_FINISH;
          end else if (in_direct) begin
            state_next = S_INS_LAST;
          end else if (in_ins) begin
            state_next = S_INS_RUN;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_INS_RUN: begin
        if (!ins_shift) begin
          state_next = S_FINISH;
        end else if (idx == '0) begin
          state_next = S_INS_LAST;
        end
      end
      S_INS_LAST: state_next = S_FINISH;
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    cmd_next   = cmd;
    item_next  = item;
    count_next = count;
    pos_next   = pos;
    idx_next   = idx;
    wptr_next  = wptr;
    hits_next  = hits;
    val_next   = val;
    sts_next   = sts;
    ram_we     = 1'b0;
    ram_waddr  = wptr;
    ram_wdata  = ram_rdata;
    ram_raddr  = idx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_next  = in_cmd;
          item_next = item_value;
          pos_next  = in_pos;
          wptr_next = '0;
          hits_next = '0;
          val_next  = '0;
          sts_next  = in_sts;
          if (in_ins) begin
            idx_next  = AW'(count - ONE_C);
            ram_raddr = AW'(count - ONE_C);
          end else begin
            idx_next  = '0;
            ram_raddr = '0;
          end
        end
      end
      S_INS_RUN: begin
        // Move one word up, or drop the new word into the gap
        ram_we    = 1'b1;
        ram_waddr = AW'(idx + 1'b1);
        if (ins_shift) begin
          ram_wdata = ram_rdata;
          if (idx == '0) begin
            pos_next = '0;
          end else begin
            idx_next  = idx - 1'b1;
            ram_raddr = idx - 1'b1;
          end
        end else begin
          ram_wdata  = item;
          count_next = count + ONE_C;
        end
      end
      S_INS_LAST: begin
        ram_we     = 1'b1;
        ram_waddr  = pos[AW-1:0];
        ram_wdata  = item;
        count_next = count + ONE_C;
      end
      S_SCAN: begin
        // Drop taken words and compact the rest toward the front; search only records a match
        if (scan_take) begin
          hits_next = hits + ONE_C;
          val_next  = ram_rdata;
        end else if (cmd != CMD_SEARCH) begin
          ram_we    = 1'b1;
          ram_waddr = wptr;
          ram_wdata = ram_rdata;
          wptr_next = wptr + 1'b1;
        end
        if (scan_last) begin
          if ((cmd inside {CMD_SEARCH, CMD_DEL_ITEM, CMD_DEL_ALL}) && (hits_next == '0)) begin
            sts_next = STS_NOTFOUND;
          end
          if (cmd == CMD_SEARCH) begin
            hits_next = '0;
          end else begin
            count_next = count - hits_next;
          end
        end else begin
          idx_next  = idx + 1'b1;
          ram_raddr = idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if ((state == S_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd  <= cmd_next;
    item <= item_next;
    pos  <= pos_next;
    idx  <= idx_next;
    wptr <= wptr_next;
    hits <= hits_next;
    val  <= val_next;
    sts  <= sts_next;
    if ((state == S_FINISH) && out_free) begin
      status        <= sts;
      result_value  <= val;
      removed_count <= hits;
      element_count <= count;
    end
  end

endmodule
